@@ rtl/assert_macros.svh @@
// Concurrent assertion shorthands for the spring force unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, reset included.
`define SFS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("spring force unit assertion failed");

// Check outside reset.
`define SFS_ASSERT_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("spring force unit assertion failed");

`endif

@@ rtl/sfs_pkg.sv @@
`timescale 1ns / 1ps
package sfs_pkg;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
  } sfs_in_t;

  typedef struct packed {
    logic               applied;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic        [30:0] force_mag;
    logic signed [31:0] tension;
  } sfs_out_t;

  localparam logic [1:0] CFG_STIFFNESS    = 2'd0;
  localparam logic [1:0] CFG_REST_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_TENSION_ONLY = 2'd2;
  localparam logic [1:0] CFG_MIN_LENGTH   = 2'd3;

  localparam int SQRT_STEPS = 33;
  localparam int QUO_W      = 32;
  localparam int LATENCY    = 3 + SQRT_STEPS + 4 + (QUO_W + 1) + 1;

  localparam logic [31:0] CAP_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] CAP_NEG = 32'h8000_0000;

endpackage

@@ rtl/sfs_div.sv @@
`timescale 1ns / 1ps
module sfs_div #(
  parameter int NW = 98,
  parameter int DW = 64,
  parameter int QW = 32,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic          ovf,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] out_tag
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [HW-1:0] head;
  logic          head_ovf;

  logic          st_v   [0:QW];
  logic          st_ovf [0:QW];
  logic [DW-1:0] st_rem [0:QW];
  logic [QW-1:0] st_low [0:QW];
  logic [DW-1:0] st_den [0:QW];
  logic [TW-1:0] st_tag [0:QW];

  assign head     = num[NW-1:QW];
  assign head_ovf = CW'(head) >= CW'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else begin
      st_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_ovf[0] <= head_ovf;
    st_rem[0] <= DW'(head);
    st_low[0] <= num[QW-1:0];
    st_den[0] <= den;
    st_tag[0] <= tag;
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DW:0] r2;
    logic        fit;
    logic [DW:0] diff;

    assign r2   = {st_rem[j], st_low[j][QW-1]};
    assign fit  = r2 >= {1'b0, st_den[j]};
    assign diff = r2 - {1'b0, st_den[j]};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[j+1] <= 1'b0;
      end else begin
        st_v[j+1] <= st_v[j];
      end
    end

    always_ff @(posedge clk) begin
      st_ovf[j+1] <= st_ovf[j];
      st_rem[j+1] <= fit ? diff[DW-1:0] : r2[DW-1:0];
      st_low[j+1] <= {st_low[j][QW-2:0], fit};
      st_den[j+1] <= st_den[j];
      st_tag[j+1] <= st_tag[j];
    end
  end

  assign out_valid = st_v[QW];
  assign ovf       = st_ovf[QW];
  assign quo       = st_low[QW];
  assign out_tag   = st_tag[QW];

endmodule

@@ rtl/spring_force_step_unit.sv @@
`timescale 1ns / 1ps
// Channel   Signals                                   Beat taken when
// command   start, busy, item                         start && !busy
// result    done, result                              done (one cycle, no hold-off)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// One beat enters per cycle while rst is low; every result follows its beat through
// difference, squares, sum, 33 square root stages (one bit per stage), stretch, products,
// partial products, numerators, the dividers (a load stage, then one quotient bit per stage) and done.
// Synchronous rst empties the pipeline and restores the register defaults.
// Nothing stalls: busy is high only while reset is held.
module spring_force_step_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sfs_pkg::sfs_in_t  item,
  output logic              done,
  output sfs_pkg::sfs_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import sfs_pkg::*;

  logic [31:0] stiffness;
  logic [30:0] rest_length;
  logic        tension_only;
  logic [30:0] min_length;
  logic [30:0] rest_eff;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign rest_eff  = (rest_length == 31'd0) ? 31'd1 : rest_length;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness    <= 32'h0001_0000;
      rest_length  <= 31'h0001_0000;
      tension_only <= 1'b0;
      min_length   <= 31'd66;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STIFFNESS:    stiffness    <= cfg_data;
        CFG_REST_LENGTH:  rest_length  <= cfg_data[30:0];
        CFG_TENSION_ONLY: tension_only <= cfg_data[0];
        CFG_MIN_LENGTH:   min_length   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // separation and absolute components
  logic signed [2:0][32:0] dv;
  logic        [2:0][32:0] dabs;
  logic                    v1;
  logic        [2:0][32:0] ad1;
  logic        [2:0]       dn1;

  assign dv[0] = {item.second_x[31], item.second_x} - {item.first_x[31], item.first_x};
  assign dv[1] = {item.second_y[31], item.second_y} - {item.first_y[31], item.first_y};
  assign dv[2] = {item.second_z[31], item.second_z} - {item.first_z[31], item.first_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dabs[i] = dv[i][32] ? 33'(-dv[i]) : 33'(dv[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ad1 <= dabs;
    for (int i = 0; i < 3; i++) begin
      dn1[i] <= dv[i][32];
    end
  end

  // squares
  logic             v2;
  logic [2:0][65:0] sq2;
  logic [2:0][32:0] ad2;
  logic [2:0]       dn2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq2[i] <= 66'(ad1[i]) * 66'(ad1[i]);
    end
    ad2 <= ad1;
    dn2 <= dn1;
  end

  // square root, one result bit per stage
  logic                   sq_v   [0:SQRT_STEPS];
  logic [65:0]            sq_rem [0:SQRT_STEPS];
  logic [32:0]            sq_res [0:SQRT_STEPS];
  logic [2:0][32:0]       sq_ad  [0:SQRT_STEPS];
  logic [2:0]             sq_dn  [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem[0] <= sq2[0] + sq2[1] + sq2[2];
    sq_res[0] <= 33'd0;
    sq_ad[0]  <= ad2;
    sq_dn[0]  <= dn2;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int B = SQRT_STEPS - 1 - k;
    logic [67:0] trial;
    logic [67:0] rem_w;
    logic        fit;

    assign trial = (68'(sq_res[k]) << (B + 1)) | (68'(1) << (2 * B));
    assign rem_w = {2'b00, sq_rem[k]};
    assign fit   = rem_w >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_rem[k+1] <= fit ? 66'(rem_w - trial) : sq_rem[k];
      sq_res[k+1] <= fit ? (sq_res[k] | (33'(1) << B)) : sq_res[k];
      sq_ad[k+1]  <= sq_ad[k];
      sq_dn[k+1]  <= sq_dn[k];
    end
  end

  // stretch
  logic [32:0]      len;
  logic [33:0]      sdiff;
  logic [33:0]      sneg_abs;
  logic             va;
  logic             applied_a;
  logic             sneg_a;
  logic [32:0]      amag_a;
  logic [32:0]      len_a;
  logic [30:0]      rest_a;
  logic [2:0][32:0] ad_a;
  logic [2:0]       dn_a;

  assign len      = sq_res[SQRT_STEPS];
  assign sdiff    = {1'b0, len} - {3'b000, rest_eff};
  assign sneg_abs = -sdiff;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    applied_a <= (len != 33'd0) && (len >= {2'b00, min_length});
    sneg_a    <= sdiff[33];
    amag_a    <= sdiff[33] ? sneg_abs[32:0] : sdiff[32:0];
    len_a     <= len;
    rest_a    <= rest_eff;
    ad_a      <= sq_ad[SQRT_STEPS];
    dn_a      <= sq_dn[SQRT_STEPS];
  end

  // stretch times stiffness, length times rest length
  logic             vb;
  logic             applied_b;
  logic             sneg_b;
  logic [64:0]      sk_b;
  logic [63:0]      den_b;
  logic [2:0][32:0] ad_b;
  logic [2:0]       dn_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    applied_b <= applied_a;
    sneg_b    <= sneg_a;
    sk_b      <= 65'(amag_a) * 65'(stiffness);
    den_b     <= 64'(len_a) * 64'(rest_a);
    ad_b      <= ad_a;
    dn_b      <= dn_a;
  end

  // partial products and tension
  logic [48:0]      tsh;
  logic [31:0]      tcap;
  logic [31:0]      tmag;
  logic             vc;
  logic             applied_c;
  logic             sneg_c;
  logic [64:0]      sk_c;
  logic [63:0]      den_c;
  logic [31:0]      tension_c;
  logic [2:0]       neg_c;
  logic [2:0][64:0] plo_c;
  logic [2:0][65:0] phi_c;

  assign tsh  = sk_b[64:16];
  assign tcap = sneg_b ? CAP_NEG : CAP_POS;
  assign tmag = (tsh > {17'd0, tcap}) ? tcap : tsh[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    applied_c <= applied_b;
    sneg_c    <= sneg_b;
    sk_c      <= sk_b;
    den_c     <= den_b;
    tension_c <= sneg_b ? -tmag : tmag;
    for (int i = 0; i < 3; i++) begin
      plo_c[i] <= 65'(sk_b[31:0]) * 65'(ad_b[i]);
      phi_c[i] <= 66'(sk_b[64:32]) * 66'(ad_b[i]);
      neg_c[i] <= dn_b[i] ^ sneg_b;
    end
  end

  // full numerators
  logic             vd;
  logic             applied_d;
  logic             sneg_d;
  logic [64:0]      sk_d;
  logic [63:0]      den_d;
  logic [31:0]      tension_d;
  logic [2:0]       neg_d;
  logic [2:0][97:0] num_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    applied_d <= applied_c;
    sneg_d    <= sneg_c;
    sk_d      <= sk_c;
    den_d     <= den_c;
    tension_d <= tension_c;
    neg_d     <= neg_c;
    for (int i = 0; i < 3; i++) begin
      num_d[i] <= 98'(plo_c[i]) + (98'(phi_c[i]) << 32);
    end
  end

  // dividers
  logic             mv;
  logic             movf;
  logic [31:0]      mq;
  logic [33:0]      mtag;
  logic [2:0]       fv;
  logic [2:0]       fovf;
  logic [2:0][31:0] fq;
  logic [2:0]       fneg;

  sfs_div #(.NW(65), .DW(31), .QW(QUO_W), .TW(34)) u_div_mag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vd),
    .num       (sk_d),
    .den       (rest_eff),
    .tag       ({applied_d, sneg_d, tension_d}),
    .out_valid (mv),
    .ovf       (movf),
    .quo       (mq),
    .out_tag   (mtag)
  );

  for (genvar i = 0; i < 3; i++) begin : g_force_div
    sfs_div #(.NW(98), .DW(64), .QW(QUO_W), .TW(1)) u_div_force (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vd),
      .num       (num_d[i]),
      .den       (den_d),
      .tag       (neg_d[i]),
      .out_valid (fv[i]),
      .ovf       (fovf[i]),
      .quo       (fq[i]),
      .out_tag   (fneg[i])
    );
  end

  // saturate, sign and hold
  logic [2:0][31:0] fval;
  logic [30:0]      magval;
  logic             slack;
  sfs_out_t         result_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [31:0] cap;
      logic [31:0] m;
      cap     = fneg[i] ? CAP_NEG : CAP_POS;
      m       = (fovf[i] || (fq[i] > cap)) ? cap : fq[i];
      fval[i] = fneg[i] ? -m : m;
    end
  end

  assign magval = (movf || (mq > CAP_POS)) ? CAP_POS[30:0] : mq[30:0];
  assign slack  = tension_only && mtag[32];

  always_comb begin
    result_next = '0;
    if (mtag[33]) begin
      result_next.applied = 1'b1;
      result_next.tension = mtag[31:0];
      if (!slack) begin
        result_next.force_x   = fval[0];
        result_next.force_y   = fval[1];
        result_next.force_z   = fval[2];
        result_next.force_mag = magval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mv && (&fv);
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

@@ rtl/sfs_check.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfs_check (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input sfs_pkg::sfs_out_t result,
  input logic              cfg_valid,
  input logic              cfg_ready
);
  import sfs_pkg::*;

  logic fields_zero;

  assign fields_zero = (result.force_x == '0) && (result.force_y == '0) &&
                       (result.force_z == '0) && (result.force_mag == '0) &&
                       (result.tension == '0);

  `SFS_ASSERT(a_busy_only_in_reset, !rst |-> !busy)
  `SFS_ASSERT_RUN(a_cfg_taken, cfg_valid |-> cfg_ready)
  `SFS_ASSERT_RUN(a_done_has_beat, done |-> $past(start && !busy, LATENCY))
  `SFS_ASSERT_RUN(a_short_is_zero, (done && !result.applied) |-> fields_zero)

endmodule

bind spring_force_step_unit sfs_check u_sfs_check (.*);

@@ test/sfs_force_monitor.sv @@
`timescale 1ns / 1ps
module sfs_force_monitor (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  sfs_pkg::sfs_in_t  item,
  input  logic              done,
  input  sfs_pkg::sfs_out_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                errors,
  output int                pending
);
  import sfs_pkg::*;

  logic [31:0] k_stiff;
  logic [30:0] k_rest;
  logic        k_rope;
  logic [30:0] k_min_len;

  sfs_out_t expected_forces[$];

  function automatic logic [31:0] clamp_signed(logic [127:0] mag, bit neg);
    logic [127:0] cap;
    logic [31:0]  v;
    cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    v = (mag > cap) ? cap[31:0] : mag[31:0];
    return neg ? -v : v;
  endfunction

  function automatic sfs_out_t spring_force(sfs_in_t p);
    sfs_out_t     r;
    longint       d[3];
    logic [127:0] ad[3];
    logic [127:0] sum, cand, len, rest, amag, sk, den, q;
    longint       s;
    bit           sneg, neg;
    r = '0;
    d[0] = longint'(p.second_x) - longint'(p.first_x);
    d[1] = longint'(p.second_y) - longint'(p.first_y);
    d[2] = longint'(p.second_z) - longint'(p.first_z);
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      ad[i] = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
      sum = sum + ad[i] * ad[i];
    end
    len = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = len | (128'd1 << b);
      if (cand * cand <= sum) len = cand;
    end
    if (len == 0 || len < 128'(k_min_len)) return r;
    rest = (k_rest == 0) ? 128'd1 : 128'(k_rest);
    s = longint'(len) - longint'(rest);
    sneg = s < 0;
    amag = sneg ? 128'(-s) : 128'(s);
    sk = amag * 128'(k_stiff);
    r.applied = 1'b1;
    r.tension = clamp_signed(sk >> 16, sneg);
    if (k_rope && sneg) return r;
    q = sk / rest;
    r.force_mag = (q > 128'h7FFF_FFFF) ? 31'h7FFF_FFFF : q[30:0];
    den = len * rest;
    for (int i = 0; i < 3; i++) begin
      neg = (d[i] < 0) != sneg;
      q = (sk * ad[i]) / den;
      case (i)
        0: r.force_x = clamp_signed(q, neg);
        1: r.force_y = clamp_signed(q, neg);
        default: r.force_z = clamp_signed(q, neg);
      endcase
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    sfs_out_t want;
    if (rst) begin
      k_stiff   <= 32'd65536;
      k_rest    <= 31'd65536;
      k_rope    <= 1'b0;
      k_min_len <= 31'd66;
      expected_forces.delete();
    end else begin
      if (done) begin
        if (expected_forces.size() == 0) begin
          errors++;
          $display("%0t unexpected result expected none actual %h", $time, result);
        end else begin
          want = expected_forces.pop_front();
          check_field("applied", 32'(want.applied), 32'(result.applied));
          check_field("force_x", want.force_x, result.force_x);
          check_field("force_y", want.force_y, result.force_y);
          check_field("force_z", want.force_z, result.force_z);
          check_field("force_mag", 32'(want.force_mag), 32'(result.force_mag));
          check_field("tension", want.tension, result.tension);
        end
      end
      if (start && !busy) begin
        expected_forces.insert(expected_forces.size(), spring_force(item));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STIFFNESS:    k_stiff   <= cfg_data;
          CFG_REST_LENGTH:  k_rest    <= cfg_data[30:0];
          CFG_TENSION_ONLY: k_rope    <= cfg_data[0];
          CFG_MIN_LENGTH:   k_min_len <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
    pending <= rst ? 0 : expected_forces.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import sfs_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  sfs_in_t     item = '0;
  logic        done;
  sfs_out_t    result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_STIFFNESS;
  logic [31:0] cfg_data = '0;
  int          errors, pending;
  bit          calm = 1'b0;

  always #5 clk = ~clk;

  spring_force_step_unit uut (.*);

  sfs_force_monitor monitor (.*);

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk) taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_beat(sfs_in_t p);
    bit taken;
    start <= 1'b1;
    item  <= p;
    do begin
      @(negedge clk) taken = !busy;
      @(posedge clk);
    end while (!taken);
    if (!calm && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      item  <= sfs_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
  endtask

  task automatic send_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                           logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
    sfs_in_t p;
    p = '{ax, ay, az, bx, by, bz};
    send_beat(p);
  endtask

  // mostly springs near their rest length, some wide open, some pure noise
  task automatic random_springs(int n, logic [31:0] rest);
    sfs_in_t p;
    logic [31:0] span;
    for (int i = 0; i < n; i++) begin
      p = sfs_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      span = (rest << $urandom_range(0, 2)) | 32'd1;
      if ($urandom_range(0, 3) != 0) begin
        p.second_x = p.first_x + $signed($urandom_range(0, 2 * span) - span);
        p.second_y = p.first_y + $signed($urandom_range(0, 2 * span) - span) /
                     int'($urandom_range(1, 4));
        p.second_z = p.first_z + $signed($urandom_range(0, 2 * span) - span) /
                     int'($urandom_range(1, 8));
      end
      send_beat(p);
    end
  endtask

  initial begin
    logic [31:0] rest;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(5, 5, 5, 5, 5, 5);
    send_pair(0, 0, 0, 65, 0, 0);
    send_pair(0, 0, 0, 66, 0, 0);
    send_pair(0, 0, 0, 32'h1_0000, 0, 0);
    send_pair(0, 0, 0, 0, 32'h8000, 0);
    send_pair(0, 0, 0, 0, 0, 32'h3_0000);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pair(32'hFFFF_FFFF, 0, 32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h1234_5678, 32'hFEDC_BA98, 0, 32'h1234_0000, 32'hFEDC_0000, 32'h100);
    random_springs(150, 32'h1_0000);
    drain();

    write_reg(CFG_STIFFNESS, 32'hFFFF_FFFF);
    write_reg(CFG_REST_LENGTH, 32'd1);
    write_reg(CFG_MIN_LENGTH, 32'd0);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 0, 1, 0, 0);
    send_pair(0, 0, 0, 2, 2, 2);
    send_pair(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
    random_springs(150, 32'd4);
    drain();

    write_reg(CFG_REST_LENGTH, 32'h7FFF_FFFF);
    write_reg(CFG_MIN_LENGTH, 32'h7FFF_FFFF);
    send_pair(0, 0, 0, 32'h7FFF_FFFF, 0, 0);
    send_pair(0, 0, 0, 32'h7FFF_FFFE, 0, 0);
    send_pair(32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    random_springs(150, 32'h4000_0000);
    drain();

    write_reg(CFG_TENSION_ONLY, 32'd1);
    write_reg(CFG_MIN_LENGTH, 32'd100);
    write_reg(CFG_REST_LENGTH, 32'h2_0000);
    write_reg(CFG_STIFFNESS, 32'h10_0000);
    send_pair(0, 0, 0, 32'h1_0000, 0, 0);
    send_pair(0, 0, 0, 32'h4_0000, 0, 0);
    send_pair(0, 0, 0, 32'h2_0000, 0, 0);
    random_springs(150, 32'h2_0000);
    drain();

    write_reg(CFG_REST_LENGTH, 32'd0);
    write_reg(CFG_TENSION_ONLY, 32'd0);
    write_reg(CFG_STIFFNESS, 32'd0);
    random_springs(100, 32'd8);
    drain();
    write_reg(CFG_STIFFNESS, 32'd1);
    random_springs(80, 32'd8);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      rest = $urandom_range(1, 32'h10_0000) >> $urandom_range(0, 16);
      if (rest == 0) rest = 1;
      write_reg(CFG_STIFFNESS, $urandom >> $urandom_range(0, 24));
      write_reg(CFG_REST_LENGTH, rest);
      write_reg(CFG_TENSION_ONLY, $urandom_range(0, 1));
      write_reg(CFG_MIN_LENGTH, rest >> $urandom_range(0, 8));
      calm = (ph == 3);
      random_springs(140, rest);
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sfs_pkg.sv
rtl/sfs_div.sv
rtl/spring_force_step_unit.sv
rtl/sfs_check.sv
test/sfs_force_monitor.sv
test/tb_top.sv
